// ----- sv/scale2x_pixel_upscaler_top_assert.svh -----
// Assertion macros shared by the scale2x upscaler modules.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SCALE2X_PIXEL_UPSCALER_TOP_ASSERT_SVH
`define SCALE2X_PIXEL_UPSCALER_TOP_ASSERT_SVH

// Property that must hold at every clock edge.
`define S2X_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication checked in the same cycle.
`define S2X_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/s2x_pkg.sv -----
// Shared types and constants for the scale2x upscaler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package s2x_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 32;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam int WIDTH_REG_BITS = 11;
    localparam int ROW_BITS       = 16;
    localparam int COL_OUT_BITS   = 10;
    localparam int PIX_OUT_BITS   = 32;
    localparam int PIX_IN_BITS    = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH  = 4;
    localparam int Q_PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int Q_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // word slots of one job
    localparam int W_PIX      = 0;
    localparam int W_LEFT0    = 1;
    localparam int W_LEFT1    = 2;
    localparam int W_UP_B     = 3;
    localparam int W_UP_D     = 4;
    localparam int W_UP_E     = 5;
    localparam int W_UP_F     = 6;
    localparam int NUM_WORDS  = 7;

    // block kinds, one bit each in the pending mask
    localparam int K_UP    = 0;
    localparam int K_LEFT  = 1;
    localparam int K_SELF  = 2;
    localparam int NUM_KINDS = 3;

    typedef struct packed {
        logic has_up;
        logic do_left;
        logic do_self;
        logic col_ge1;
        logic col_ge2;
    } t_job_flags;

endpackage

// ----- sv/s2x_front.sv -----
// Front end: config registers, raster counters, line stores and job build.
// Depends on s2x_pkg; feeds jobs to s2x_queue.
`timescale 1ns / 1ps
`include "scale2x_pixel_upscaler_top_assert.svh"

module s2x_front
    import s2x_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    parameter int CW         = $clog2(MAX_WIDTH)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]              i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]               i_cfg_wdata,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [PIX_IN_BITS-1:0]                 i_pixel,
    input  logic [Q_COUNT_BITS-1:0]                i_q_count,
    output logic                                   o_job_valid,
    output t_job_flags                             o_job_flags,
    output logic [ROW_BITS-1:0]                    o_job_row,
    output logic [CW-1:0]                          o_job_col,
    output logic [NUM_WORDS-1:0][PIXEL_BITS-1:0]   o_job_words
);

    logic [WIDTH_REG_BITS-1:0] r_width;
    logic [ROW_BITS-1:0]       r_height;

    logic                  r_bank;
    logic [CW-1:0]         r_col;
    logic [ROW_BITS-1:0]   r_row;
    logic [PIXEL_BITS-1:0] r_lp0;
    logic [PIXEL_BITS-1:0] r_lp1;

    logic [PIXEL_BITS-1:0] line_store_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] line_store_b [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_rd_a0, r_rd_a1, r_rd_b0, r_rd_b1;

    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_pix, r_s1_lp0, r_s1_lp1;
    logic [ROW_BITS-1:0]   r_s1_row;
    logic [CW-1:0]         r_s1_col;
    logic                  r_s1_bank, r_s1_has_up, r_s1_row_ge2, r_s1_last_row, r_s1_row_end;
    logic                  r_s1_col_ge1, r_s1_col_ge2;
    logic [PIXEL_BITS-1:0] r_last_e;

    logic                  accept;
    logic [PIXEL_BITS-1:0] pix;
    logic [CW-1:0]         wm1, col_r;
    logic [ROW_BITS-1:0]   hm1;
    logic                  row_end, last_row;
    logic [PIXEL_BITS-1:0] cur0, prev0, prev1;

    assign pix     = i_pixel[PIXEL_BITS-1:0];
    assign o_ready = ({1'b0, i_q_count} + (Q_COUNT_BITS+1)'(r_s1_valid))
                     < (Q_COUNT_BITS+1)'(QUEUE_DEPTH);
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (r_width == '0) begin
            wm1 = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(32'(r_width) - 32'd1);
        end
        hm1      = (r_height == '0) ? '0 : r_height - 16'd1;
        row_end  = r_col >= wm1;
        last_row = r_row >= hm1;
        col_r    = (r_col < wm1) ? r_col + CW'(1) : wm1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_REG_BITS'(1);
            r_height <= ROW_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[WIDTH_REG_BITS-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
            r_lp0  <= '0;
            r_lp1  <= '0;
        end else if (accept) begin
            r_lp1 <= r_lp0;
            r_lp0 <= pix;
            if (row_end) begin
                r_col  <= '0;
                r_bank <= ~r_bank;
                r_row  <= last_row ? '0 : r_row + 16'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // read-first: the old word at the write address comes back
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_a0 <= line_store_a[r_col];
            r_rd_a1 <= line_store_a[col_r];
            if (!r_bank) begin
                line_store_a[r_col] <= pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_b0 <= line_store_b[r_col];
            r_rd_b1 <= line_store_b[col_r];
            if (r_bank) begin
                line_store_b[r_col] <= pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= pix;
            r_s1_lp0      <= r_lp0;
            r_s1_lp1      <= r_lp1;
            r_s1_row      <= r_row;
            r_s1_col      <= r_col;
            r_s1_bank     <= r_bank;
            r_s1_has_up   <= r_row != '0;
            r_s1_row_ge2  <= r_row >= 16'd2;
            r_s1_last_row <= last_row;
            r_s1_row_end  <= row_end;
            r_s1_col_ge1  <= r_col != '0;
            r_s1_col_ge2  <= 32'(r_col) >= 32'd2;
        end
        if (r_s1_valid) begin
            r_last_e <= prev0;
        end
    end

    assign cur0  = r_s1_bank ? r_rd_b0 : r_rd_a0;
    assign prev0 = r_s1_bank ? r_rd_a0 : r_rd_b0;
    assign prev1 = r_s1_bank ? r_rd_a1 : r_rd_b1;

    always_comb begin
        o_job_valid                = r_s1_valid;
        o_job_row                  = r_s1_row;
        o_job_col                  = r_s1_col;
        o_job_flags.has_up         = r_s1_has_up;
        o_job_flags.do_left        = r_s1_last_row && r_s1_col_ge1;
        o_job_flags.do_self        = r_s1_last_row && r_s1_row_end;
        o_job_flags.col_ge1        = r_s1_col_ge1;
        o_job_flags.col_ge2        = r_s1_col_ge2;
        o_job_words[W_PIX]         = r_s1_pix;
        o_job_words[W_LEFT0]       = r_s1_lp0;
        o_job_words[W_LEFT1]       = r_s1_lp1;
        o_job_words[W_UP_B]        = r_s1_row_ge2 ? cur0 : prev0;
        o_job_words[W_UP_D]        = r_s1_col_ge1 ? r_last_e : prev0;
        o_job_words[W_UP_E]        = prev0;
        o_job_words[W_UP_F]        = prev1;
    end

    `S2X_ASSERT_IMPLIES(a_front_room, r_s1_valid, i_q_count < Q_COUNT_BITS'(QUEUE_DEPTH),
        "job staged with no queue slot")

endmodule

// ----- sv/s2x_queue.sv -----
// Short job queue between front and back, first word falls through.
// Depends on s2x_pkg for depth and pointer widths.
`timescale 1ns / 1ps
`include "scale2x_pixel_upscaler_top_assert.svh"

module s2x_queue
    import s2x_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_data,
    input  logic                    i_pop,
    output logic                    o_valid,
    output logic [WIDTH-1:0]        o_data,
    output logic [Q_COUNT_BITS-1:0] o_count
);

    logic [WIDTH-1:0]        r_mem [QUEUE_DEPTH];
    logic [Q_PTR_BITS-1:0]   r_wptr, r_rptr;
    logic [Q_COUNT_BITS-1:0] r_count;

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_PTR_BITS'(1);
            end
            r_count <= r_count + Q_COUNT_BITS'(i_push) - Q_COUNT_BITS'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `S2X_ASSERT_ALWAYS(a_q_no_overflow,
        !(i_push && !i_pop && r_count == Q_COUNT_BITS'(QUEUE_DEPTH)), "queue overflow")
    `S2X_ASSERT_ALWAYS(a_q_no_underflow, !(i_pop && r_count == '0), "queue underflow")

endmodule

// ----- sv/s2x_back.sv -----
// Back end: expands each job into up to three Scale2x blocks, one per cycle unless the output stalls.
// Depends on s2x_pkg; drains s2x_queue and drives the output register.
`timescale 1ns / 1ps
`include "scale2x_pixel_upscaler_top_assert.svh"

module s2x_back
    import s2x_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    parameter int CW         = $clog2(MAX_WIDTH)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_job_valid,
    input  t_job_flags                           i_job_flags,
    input  logic [ROW_BITS-1:0]                  i_job_row,
    input  logic [CW-1:0]                        i_job_col,
    input  logic [NUM_WORDS-1:0][PIXEL_BITS-1:0] i_job_words,
    output logic                                 o_job_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [ROW_BITS-1:0]                  o_row,
    output logic [COL_OUT_BITS-1:0]              o_col,
    output logic [PIX_OUT_BITS-1:0]              o_top_left,
    output logic [PIX_OUT_BITS-1:0]              o_top_right,
    output logic [PIX_OUT_BITS-1:0]              o_bottom_left,
    output logic [PIX_OUT_BITS-1:0]              o_bottom_right,
    output logic                                 o_last
);

    logic [NUM_KINDS-1:0] r_done;
    logic                 r_out_valid;

    logic [NUM_KINDS-1:0] req, pend, sel;
    logic                 single, load;
    logic [PIXEL_BITS-1:0] b, d, e, f, h, p, lp0, lp1;
    logic [ROW_BITS-1:0]  row;
    logic [CW-1:0]        col;
    logic                 last;
    logic [PIXEL_BITS-1:0] tl, tr, bl, br;

    always_comb begin
        req[K_UP]   = i_job_flags.has_up;
        req[K_LEFT] = i_job_flags.do_left;
        req[K_SELF] = i_job_flags.do_self;
        pend        = req & ~r_done;
        sel         = pend & (~pend + NUM_KINDS'(1));
        single      = (pend & (pend - NUM_KINDS'(1))) == '0;
        load        = i_job_valid && (pend != '0) && (!r_out_valid || i_ready);
        o_job_pop   = i_job_valid && ((pend == '0) || (load && single));
    end

    always_comb begin
        p   = i_job_words[W_PIX];
        lp0 = i_job_words[W_LEFT0];
        lp1 = i_job_words[W_LEFT1];
        b    = p;
        d    = p;
        e    = p;
        f    = p;
        h    = p;
        row  = i_job_row;
        col  = i_job_col;
        last = 1'b0;
        case (1'b1)
            sel[K_UP]: begin
                b   = i_job_words[W_UP_B];
                d   = i_job_words[W_UP_D];
                e   = i_job_words[W_UP_E];
                f   = i_job_words[W_UP_F];
                row = i_job_row - 16'd1;
            end
            sel[K_LEFT]: begin
                e   = lp0;
                h   = lp0;
                d   = i_job_flags.col_ge2 ? lp1 : lp0;
                b   = i_job_flags.has_up ? i_job_words[W_UP_D] : lp0;
                col = i_job_col - CW'(1);
            end
            sel[K_SELF]: begin
                b    = i_job_flags.has_up ? i_job_words[W_UP_E] : p;
                d    = i_job_flags.col_ge1 ? lp0 : p;
                last = 1'b1;
            end
            default: ;
        endcase
        tl = (d == b && b != f && d != h) ? d : e;
        tr = (b == f && b != d && f != h) ? f : e;
        bl = (d == h && d != b && h != f) ? d : e;
        br = (h == f && d != h && b != f) ? f : e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_done <= '0;
            end else if (load) begin
                r_done <= r_done | sel;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_row          <= row;
            o_col          <= COL_OUT_BITS'(col);
            o_top_left     <= PIX_OUT_BITS'(tl);
            o_top_right    <= PIX_OUT_BITS'(tr);
            o_bottom_left  <= PIX_OUT_BITS'(bl);
            o_bottom_right <= PIX_OUT_BITS'(br);
            o_last         <= last;
        end
    end

    assign o_valid = r_out_valid;

    `S2X_ASSERT_IMPLIES(a_back_done_subset, i_job_valid, (r_done & ~req) == '0,
        "done mask holds a block the job never asked for")

endmodule

// ----- sv/scale2x_pixel_upscaler_top.sv -----
// Scale2x 2x upscaler top level: front, job queue and back end.
// Depends on s2x_pkg, s2x_front, s2x_queue and s2x_back.
//
//   channel   dir  handshake                       payload
//   s_axis    in   i_s_axis_tvalid/o_s_axis_tready pixel
//   m_axis    out  o_m_axis_tvalid/i_m_axis_tready 2x2 block, tlast = end of image
//   cfg       in   i_cfg_we                        image_width, image_height
//
// One pixel per cycle while o_s_axis_tready is high; jobs pass staging, queue and output registers.
// Last-row pixels that make two or three blocks hold the back end until each is loaded.
// Rate is set by the back end's single Scale2x compare unit and the four-entry queue.
// i_rst_n is synchronous; line stores are not cleared.
// o_s_axis_tready drops only when the queue and staged job fill all four slots.
`timescale 1ns / 1ps

module scale2x_pixel_upscaler_top
    import s2x_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [31:0]               i_s_axis_tdata,   // pixel[31:0]
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // src_row[15:0] src_col[25:16] top_left[57:26] top_right[89:58]
    // bottom_left[121:90] bottom_right[153:122] zero[159:154]
    output logic [159:0]              o_m_axis_tdata,
    output logic                      o_m_axis_tlast    // end_of_image
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FW = $bits(t_job_flags);
    localparam int WW = NUM_WORDS * PIXEL_BITS;
    localparam int QW = FW + ROW_BITS + CW + WW;

    logic [Q_COUNT_BITS-1:0]               q_count;
    logic                                  push;
    t_job_flags                            f_flags, b_flags;
    logic [ROW_BITS-1:0]                   f_row, b_row;
    logic [CW-1:0]                         f_col, b_col;
    logic [NUM_WORDS-1:0][PIXEL_BITS-1:0]  f_words, b_words;
    logic [QW-1:0]                         q_in, q_out;
    logic                                  q_valid, q_pop;

    logic [ROW_BITS-1:0]     out_row;
    logic [COL_OUT_BITS-1:0] out_col;
    logic [PIX_OUT_BITS-1:0] out_tl, out_tr, out_bl, out_br;

    s2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_pixel     (i_s_axis_tdata),
        .i_q_count   (q_count),
        .o_job_valid (push),
        .o_job_flags (f_flags),
        .o_job_row   (f_row),
        .o_job_col   (f_col),
        .o_job_words (f_words)
    );

    assign q_in = {f_flags, f_row, f_col, f_words};

    s2x_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    assign b_flags = t_job_flags'(q_out[QW-1 -: FW]);
    assign b_row   = q_out[CW+WW +: ROW_BITS];
    assign b_col   = q_out[WW +: CW];
    assign b_words = q_out[WW-1:0];

    s2x_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job_flags    (b_flags),
        .i_job_row      (b_row),
        .i_job_col      (b_col),
        .i_job_words    (b_words),
        .o_job_pop      (q_pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_row          (out_row),
        .o_col          (out_col),
        .o_top_left     (out_tl),
        .o_top_right    (out_tr),
        .o_bottom_left  (out_bl),
        .o_bottom_right (out_br),
        .o_last         (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'b0, out_br, out_bl, out_tr, out_tl, out_col, out_row};

endmodule

// ----- sim/testbench.sv -----
// Testbench for the scale2x pixel upscaler: drives pixel items, writes image size registers
// and checks all output blocks against a built-in line-store predictor or directed values.
// Depends on s2x_pkg and scale2x_pixel_upscaler_top.
`timescale 1ns / 1ps

module testbench;
    import s2x_pkg::*;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam logic [31:0] PIX_MASK = 32'hFFFF_FFFF >> (32 - DEF_PIXEL_BITS);
    localparam logic [31:0] PX_A = 32'h1234_5678;
    localparam logic [31:0] PX_B = 32'h8765_4321;
    localparam logic [31:0] PX_C = 32'hFFFF_0000;

    typedef struct packed {
        logic [ROW_BITS-1:0]     src_row;
        logic [COL_OUT_BITS-1:0] src_col;
        logic [PIX_OUT_BITS-1:0] top_left;
        logic [PIX_OUT_BITS-1:0] top_right;
        logic [PIX_OUT_BITS-1:0] bottom_left;
        logic [PIX_OUT_BITS-1:0] bottom_right;
        logic                    end_of_image;
    } t_s2x_block;

    typedef enum logic {STEP_PIXEL, STEP_CONFIG} t_step_kind;

    typedef struct packed {
        t_step_kind                kind;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  value;
        logic [31:0]               pixel;
        logic                      typed;
        t_s2x_block                want;
    } t_stim_row;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [31:0]               s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [159:0]              m_tdata;
    logic                      m_tlast;

    // predictor state
    bit [31:0]                 store_a [MAX_W];
    bit [31:0]                 store_b [MAX_W];
    bit                        row_bank;
    int unsigned               col_cnt;
    int unsigned               row_cnt;
    bit [31:0]                 prev_px;
    bit [31:0]                 prev2_px;
    bit [WIDTH_REG_BITS-1:0]   reg_width;
    bit [15:0]                 reg_height;

    t_s2x_block                step_blocks[$];
    t_s2x_block                pending_blocks[$];
    t_stim_row                 directed[$];
    t_s2x_block                got_blk;
    t_s2x_block                want_blk;
    int                        error_count;
    int                        src_idle_pct;
    int                        snk_idle_pct;

    scale2x_pixel_upscaler_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_width();
        if (reg_width == 0) return 1;
        if (reg_width > MAX_W) return MAX_W;
        return 32'(reg_width);
    endfunction

    function automatic int unsigned eff_height();
        return (reg_height == 0) ? 1 : 32'(reg_height);
    endfunction

    // row just above the incoming one
    function automatic bit [31:0] upper_row(int unsigned idx);
        return row_bank ? store_a[idx] : store_b[idx];
    endfunction

    // row two above the incoming one, before it is overwritten
    function automatic bit [31:0] two_up(int unsigned idx);
        return row_bank ? store_b[idx] : store_a[idx];
    endfunction

    function automatic t_s2x_block epx_block(int unsigned row, int unsigned col,
                                             bit [31:0] b, bit [31:0] d, bit [31:0] e,
                                             bit [31:0] f, bit [31:0] h, bit eoi);
        t_s2x_block blk;
        blk.src_row      = row[ROW_BITS-1:0];
        blk.src_col      = col[COL_OUT_BITS-1:0];
        blk.top_left     = (d == b && b != f && d != h) ? d : e;
        blk.top_right    = (b == f && b != d && f != h) ? f : e;
        blk.bottom_left  = (d == h && d != b && h != f) ? d : e;
        blk.bottom_right = (h == f && d != h && b != f) ? f : e;
        blk.end_of_image = eoi;
        return blk;
    endfunction

    task automatic scale2x_predict(input logic [31:0] pixel_in);
        int unsigned w, ht, c, r, cl, cr;
        bit [31:0]   px, b, d, e;
        w  = eff_width();
        ht = eff_height();
        c  = col_cnt;
        r  = row_cnt;
        px = pixel_in & PIX_MASK;
        if (c >= MAX_W) c = MAX_W - 1;
        cl = (c != 0) ? c - 1 : 0;
        cr = (c + 1 < w) ? c + 1 : w - 1;
        step_blocks.delete();
        if (r >= 1)
            step_blocks.push_back(epx_block(r - 1, c, (r >= 2) ? two_up(c) : upper_row(c),
                                            upper_row(cl), upper_row(c), upper_row(cr), px, 1'b0));
        if (row_bank) store_b[c] = px;
        else store_a[c] = px;
        if (r >= ht - 1) begin
            if (c >= 1) begin
                e = prev_px;
                d = (c >= 2) ? prev2_px : prev_px;
                b = (r >= 1) ? upper_row(c - 1) : e;
                step_blocks.push_back(epx_block(r, c - 1, b, d, e, px, e, 1'b0));
            end
            if (c >= w - 1) begin
                b = (r >= 1) ? upper_row(c) : px;
                d = (c >= 1) ? prev_px : px;
                step_blocks.push_back(epx_block(r, c, b, d, px, px, px, 1'b1));
            end
        end
        prev2_px = prev_px;
        prev_px  = px;
        if (c >= w - 1) begin
            col_cnt  = 0;
            row_bank = ~row_bank;
            row_cnt  = (r >= ht - 1) ? 0 : ((r + 1) & 16'hFFFF);
        end else begin
            col_cnt = c + 1;
        end
    endtask

    // entered and left at a falling edge
    task automatic send_pixel(input logic [31:0] px, input logic typed, input t_s2x_block want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        scale2x_predict(px);
        if (typed) pending_blocks.push_back(want);
        else foreach (step_blocks[k]) pending_blocks.push_back(step_blocks[k]);
        @(negedge clk);
    endtask

    task automatic drain_blocks(input int extra);
        s_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) reg_width = val[WIDTH_REG_BITS-1:0];
        else reg_height = val;
    endtask

    // one whole image at the current size, colors mostly drawn from a small palette
    task automatic send_image();
        int          npx, ncol, pause_at;
        logic [31:0] palette [4];
        npx  = eff_width() * eff_height();
        ncol = $urandom_range(4, 2);
        foreach (palette[k]) palette[k] = $urandom;
        pause_at = ($urandom_range(3) == 0) ? $urandom_range(npx - 1) : -1;
        for (int i = 0; i < npx; i++) begin
            if (i == pause_at) drain_blocks(0);
            send_pixel(($urandom_range(9) == 0) ? $urandom : palette[$urandom_range(ncol - 1)],
                       1'b0, '0);
        end
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int n_items);
        int          sent, w, h;
        logic [15:0] wv, hv;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < n_items) begin
            if (sent == 0 || $urandom_range(3) != 0) begin
                w = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                h = $urandom_range(5, 1);
                wv = 16'(w);
                hv = 16'(h);
                if (w == 1 && $urandom_range(1) == 0) wv = '0;
                if ($urandom_range(3) == 0) wv[15:11] = 5'($urandom);
                if (h == 1 && $urandom_range(1) == 0) hv = '0;
                drain_blocks(8);
                write_reg(REG_IMAGE_WIDTH, wv);
                write_reg(REG_IMAGE_HEIGHT, hv);
            end
            sent += eff_width() * eff_height();
            send_image();
        end
    endtask

    task automatic check_block(input t_s2x_block want, input t_s2x_block got);
        if (got.src_row !== want.src_row) begin
            $error("src_row: expected %0d, got %0d", want.src_row, got.src_row);
            error_count++;
        end
        if (got.src_col !== want.src_col) begin
            $error("src_col: expected %0d, got %0d", want.src_col, got.src_col);
            error_count++;
        end
        if (got.top_left !== want.top_left) begin
            $error("top_left: expected %h, got %h", want.top_left, got.top_left);
            error_count++;
        end
        if (got.top_right !== want.top_right) begin
            $error("top_right: expected %h, got %h", want.top_right, got.top_right);
            error_count++;
        end
        if (got.bottom_left !== want.bottom_left) begin
            $error("bottom_left: expected %h, got %h", want.bottom_left, got.bottom_left);
            error_count++;
        end
        if (got.bottom_right !== want.bottom_right) begin
            $error("bottom_right: expected %h, got %h", want.bottom_right, got.bottom_right);
            error_count++;
        end
        if (got.end_of_image !== want.end_of_image) begin
            $error("end_of_image: expected %0d, got %0d", want.end_of_image, got.end_of_image);
            error_count++;
        end
    endtask

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got_blk.src_row      = m_tdata[15:0];
            got_blk.src_col      = m_tdata[25:16];
            got_blk.top_left     = m_tdata[57:26];
            got_blk.top_right    = m_tdata[89:58];
            got_blk.bottom_left  = m_tdata[121:90];
            got_blk.bottom_right = m_tdata[153:122];
            got_blk.end_of_image = m_tlast;
            if (pending_blocks.size() == 0) begin
                $error("unexpected block at row %0d col %0d", got_blk.src_row, got_blk.src_col);
                error_count++;
            end else begin
                want_blk = pending_blocks.pop_front();
                check_block(want_blk, got_blk);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_IMAGE_WIDTH;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        error_count  = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        row_bank     = 1'b0;
        col_cnt      = 0;
        row_cnt      = 0;
        prev_px      = '0;
        prev2_px     = '0;
        reg_width    = 1;
        reg_height   = 1;

        // 1x1 images give the pixel itself in all four positions
        directed.push_back('{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0, 32'h0000_0000, 1'b1,
                             '{16'd0, 10'd0, 32'h0000_0000, 32'h0000_0000,
                               32'h0000_0000, 32'h0000_0000, 1'b1}});
        directed.push_back('{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0, 32'hFFFF_FFFF, 1'b1,
                             '{16'd0, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}});
        directed.push_back('{STEP_CONFIG, REG_IMAGE_WIDTH, 16'd0, 32'd0, 1'b0, '0});
        directed.push_back('{STEP_CONFIG, REG_IMAGE_HEIGHT, 16'd0, 32'd0, 1'b0, '0});
        directed.push_back('{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0, 32'h5A5A_A5A5, 1'b1,
                             '{16'd0, 10'd0, 32'h5A5A_A5A5, 32'h5A5A_A5A5,
                               32'h5A5A_A5A5, 32'h5A5A_A5A5, 1'b1}});
        directed.push_back('{STEP_CONFIG, REG_IMAGE_WIDTH, 16'd3, 32'd0, 1'b0, '0});
        directed.push_back('{STEP_CONFIG, REG_IMAGE_HEIGHT, 16'd3, 32'd0, 1'b0, '0});
        begin
            logic [31:0] grid3 [9];
            logic [31:0] grid4 [8];
            grid3 = '{PX_A, PX_A, PX_B, PX_A, PX_B, PX_B, PX_C, PX_B, PX_B};
            grid4 = '{PX_A, PX_B, PX_B, PX_C, PX_B, PX_A, PX_C, PX_C};
            foreach (grid3[i])
                directed.push_back('{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0, grid3[i], 1'b0, '0});
            directed.push_back('{STEP_CONFIG, REG_IMAGE_WIDTH, 16'd4, 32'd0, 1'b0, '0});
            directed.push_back('{STEP_CONFIG, REG_IMAGE_HEIGHT, 16'd5, 32'd0, 1'b0, '0});
            foreach (grid4[i])
                directed.push_back('{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0, grid4[i], 1'b0, '0});
        end
        // shrink the image mid-way: row two becomes the last, two pixels wide
        directed.push_back('{STEP_CONFIG, REG_IMAGE_HEIGHT, 16'd3, 32'd0, 1'b0, '0});
        directed.push_back('{STEP_CONFIG, REG_IMAGE_WIDTH, 16'd2, 32'd0, 1'b0, '0});
        directed.push_back('{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0, PX_C, 1'b0, '0});
        directed.push_back('{STEP_PIXEL, REG_IMAGE_WIDTH, 16'd0, PX_A, 1'b0, '0});

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i]) begin
            if (directed[i].kind == STEP_CONFIG) begin
                drain_blocks(8);
                write_reg(directed[i].index, directed[i].value);
            end else begin
                send_pixel(directed[i].pixel, directed[i].typed, directed[i].want);
            end
        end

        run_phase(8, 72, 70);
        run_phase(72, 8, 70);
        run_phase(0, 0, 60);

        // widest width value: bits above the register drop, 2047 clamps to the maximum;
        // narrow the row afterwards to end the image
        drain_blocks(8);
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        for (int i = 0; i < 6; i++) send_pixel(32'($urandom), 1'b0, '0);
        drain_blocks(8);
        write_reg(REG_IMAGE_WIDTH, 16'd7);
        send_pixel(PX_B, 1'b0, '0);

        // tallest height value, cut short after three rows
        drain_blocks(8);
        write_reg(REG_IMAGE_WIDTH, 16'd2);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_pixel(32'($urandom), 1'b0, '0);
        drain_blocks(8);
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        send_pixel(PX_A, 1'b0, '0);
        send_pixel(PX_C, 1'b0, '0);

        drain_blocks(20);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
